[hdl/kra_pkg.sv]
package kra_pkg;

  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned SectorBytesDef  = 512;

  localparam logic [15:0] MaxRun = 16'hFFFF;

  localparam logic [2:0] ModePut   = 3'd0;
  localparam logic [2:0] ModeGet   = 3'd1;
  localparam logic [2:0] ModeEvict = 3'd2;
  localparam logic [2:0] ModePin   = 3'd3;
  localparam logic [2:0] ModeUnpin = 3'd4;
  localparam logic [2:0] ModeSync  = 3'd5;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StSize    = 3'd1;
  localparam logic [2:0] StExists  = 3'd2;
  localparam logic [2:0] StNoSpace = 3'd3;
  localparam logic [2:0] StNotFnd  = 3'd4;
  localparam logic [2:0] StBusy    = 3'd5;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActDirty = 2'd1;
  localparam logic [1:0] ActClean = 2'd2;

  localparam logic [1:0] RegLogStart = 2'd0;
  localparam logic [1:0] RegTotal    = 2'd1;
  localparam logic [1:0] RegBudget   = 2'd2;

  typedef struct packed {
    logic [31:0] len;
    logic [15:0] sect;
    logic [15:0] start;
    logic [31:0] key;
  } entry_t;

endpackage

[hdl/keyed_run_allocator_index_top.sv]
// Keyed run allocator index: a table of keyed entries, each describing a
// contiguous sector run (one header sector plus payload sectors), placed
// first-fit from log_region_start. Entry data lives in a synchronous memory
// with one read and one write port; valid and pinned marks are flip-flops. One
// transaction is handled at a time. Get, evict, pin, unpin, sync and rejected
// puts present their result after one key scan through the memory port. An
// accepted put then tries the log start and the end of each valid entry as
// candidate starts, running a full overlap scan for each candidate that fits
// and lies below the best so far, all bound by the one memory read port.
// SECTOR_BYTES must be a power of two. No clearing pass is needed after reset.
module keyed_run_allocator_index_top
  import kra_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned SECTOR_BYTES  = SectorBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // mode, key, byte_length
  input  logic [71:0]   s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // status, run_start, run_length, entry_bytes, sequence_res, superblock_action
  output logic [103:0]  m_axis_tdata_o
);

  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int SBL = $clog2(SECTOR_BYTES);
  localparam logic [CW-1:0] NEnt = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    StIdle, StKscan, StDecide, StCand, StCandEv, StOscan, StWrite, StOut
  } state_e;

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_q;
  logic [IW-1:0] raddr;
  logic          mem_we;

  state_e state_q, state_d;
  logic [CW-1:0] ia_q, ia_d, jc_q, jc_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic [2:0]    mode_q, mode_d;
  logic [31:0]   key_q, key_d, len_q, len_d;
  logic          found_q, found_d, ffree_q, ffree_d;
  logic [IW-1:0] slot_q, slot_d, free_q, free_d;
  entry_t        hit_q, hit_d;
  logic [15:0]   run_q, run_d;
  logic          cfirst_q, cfirst_d, bfound_q, bfound_d, ov_q, ov_d;
  logic [16:0]   cand_q, cand_d, best_q, best_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d, pin_q, pin_d;
  logic [16:0]   live_q, live_d;
  logic [31:0]   seq_q, seq_d;
  logic          dirty_q, dirty_d;
  logic [15:0]   lstart_q, lstart_d, total_q, total_d, budget_q, budget_d;
  logic [2:0]    rst_st_q, rst_st_d;
  logic [15:0]   rrs_q, rrs_d, rrl_q, rrl_d;
  logic [31:0]   reb_q, reb_d, rseq_q, rseq_d;
  logic [1:0]    ract_q, ract_d;
  logic          ovld_q, ovld_d;
  logic [103:0]  odata_q, odata_d;

  logic [32:0] cnt33;
  logic [33:0] need;
  logic [16:0] cand_w, rd_end;
  logic        cand_ok;

  assign s_axis_tready_o = (state_q == StIdle) && !ovld_q;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;

  assign cnt33 = 33'd1 + (({1'b0, len_q} + 33'(SECTOR_BYTES - 1)) >> SBL);
  assign need  = {17'd0, live_q} + {1'b0, cnt33};
  assign rd_end = {1'b0, rd_q.start} + {1'b0, rd_q.sect};

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
    if (mem_we) begin
      mem_q[free_q] <= '{len: len_q, sect: run_q, start: best_q[15:0], key: key_q};
    end
  end

  always_comb begin
    state_d = state_q; ia_d = ia_q; jc_d = jc_q; pv_d = pv_q; pidx_d = pidx_q;
    mode_d = mode_q; key_d = key_q; len_d = len_q;
    found_d = found_q; ffree_d = ffree_q; slot_d = slot_q; free_d = free_q;
    hit_d = hit_q; run_d = run_q; cfirst_d = cfirst_q; bfound_d = bfound_q;
    ov_d = ov_q; cand_d = cand_q; best_d = best_q;
    valid_d = valid_q; pin_d = pin_q; live_d = live_q; seq_d = seq_q;
    dirty_d = dirty_q; lstart_d = lstart_q; total_d = total_q; budget_d = budget_q;
    rst_st_d = rst_st_q; rrs_d = rrs_q; rrl_d = rrl_q; reb_d = reb_q;
    rseq_d = rseq_q; ract_d = ract_q; ovld_d = ovld_q; odata_d = odata_q;
    raddr = ia_q[IW-1:0];
    mem_we = 1'b0;
    cand_w = cand_q;
    cand_ok = 1'b0;

    if (ovld_q && m_axis_tready_i) begin
      ovld_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLogStart: lstart_d = cfg_data_i;
        RegTotal:    total_d  = cfg_data_i;
        RegBudget:   budget_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          mode_d = s_axis_tdata_i[2:0];
          key_d  = s_axis_tdata_i[34:3];
          len_d  = s_axis_tdata_i[66:35];
          ia_d = '0; pv_d = 1'b0; found_d = 1'b0; ffree_d = 1'b0;
          rst_st_d = StOk; rrs_d = '0; rrl_d = '0; reb_d = '0; rseq_d = '0;
          ract_d = ActNone;
          state_d = StKscan;
        end
      end
      StKscan, StOscan: begin
        if (ia_q < NEnt) begin
          pv_d = 1'b1; pidx_d = ia_q[IW-1:0]; ia_d = ia_q + 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q && valid_q[pidx_q]) begin
          if (state_q == StKscan) begin
            if (!found_q && rd_q.key == key_q) begin
              found_d = 1'b1; slot_d = pidx_q; hit_d = rd_q;
            end
          end else if (cand_q < rd_end &&
                       {2'b0, rd_q.start} < {1'b0, cand_q} + {2'b0, run_q}) begin
            ov_d = 1'b1;
          end
        end
        if (state_q == StKscan && pv_q && !valid_q[pidx_q] && !ffree_q) begin
          ffree_d = 1'b1; free_d = pidx_q;
        end
        if (ia_q == NEnt && !pv_q) begin
          if (state_q == StKscan) begin
            state_d = StDecide;
          end else begin
            if (!ov_q) begin
              best_d = cand_q; bfound_d = 1'b1;
            end
            state_d = StCand;
          end
        end
      end
      StDecide: begin
        state_d = StOut;
        if (mode_q == ModePut) begin
          run_d = cnt33[15:0];
          if (len_q == '0) rst_st_d = StSize;
          else if (found_q) rst_st_d = StExists;
          else if (!ffree_q) rst_st_d = StNoSpace;
          else if (cnt33 > {17'd0, MaxRun}) rst_st_d = StSize;
          else if (need > {18'd0, budget_q}) rst_st_d = StNoSpace;
          else begin
            ract_d = dirty_q ? ActNone : ActDirty;
            dirty_d = 1'b1;
            cfirst_d = 1'b1; jc_d = '0; bfound_d = 1'b0;
            state_d = StCand;
          end
        end else if (mode_q == ModeGet || mode_q == ModeEvict ||
                     mode_q == ModePin || mode_q == ModeUnpin) begin
          if (!found_q) rst_st_d = StNotFnd;
          else if (mode_q == ModeEvict && pin_q[slot_q]) rst_st_d = StBusy;
          else begin
            rrs_d = hit_q.start; rrl_d = hit_q.sect; reb_d = hit_q.len;
            if (mode_q != ModeGet) begin
              ract_d = dirty_q ? ActNone : ActDirty;
              dirty_d = 1'b1;
            end
            if (mode_q == ModeEvict) begin
              valid_d[slot_q] = 1'b0; pin_d[slot_q] = 1'b0;
              live_d = live_q - {1'b0, hit_q.sect};
            end
            if (mode_q == ModePin) pin_d[slot_q] = 1'b1;
            if (mode_q == ModeUnpin) pin_d[slot_q] = 1'b0;
          end
        end else if (mode_q == ModeSync) begin
          dirty_d = 1'b0; ract_d = ActClean;
        end
      end
      StCand: begin
        raddr = jc_q[IW-1:0];
        if (cfirst_q) begin
          cfirst_d = 1'b0;
          cand_w = {1'b0, lstart_q};
          cand_ok = 1'b1;
        end else if (jc_q == NEnt) begin
          if (bfound_q) state_d = StWrite;
          else begin
            rst_st_d = StNoSpace; state_d = StOut;
          end
        end else begin
          state_d = StCandEv;
        end
      end
      StCandEv: begin
        jc_d = jc_q + 1'b1;
        state_d = StCand;
        if (valid_q[jc_q[IW-1:0]] && rd_end >= {1'b0, lstart_q}) begin
          cand_w = rd_end;
          cand_ok = 1'b1;
        end
      end
      StWrite: begin
        mem_we = 1'b1;
        valid_d[free_q] = 1'b1; pin_d[free_q] = 1'b0;
        live_d = live_q + {1'b0, run_q};
        rrs_d = best_q[15:0]; rrl_d = run_q; reb_d = len_q; rseq_d = seq_q;
        seq_d = seq_q + 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d = 1'b1;
          odata_d = {3'd0, ract_q, rseq_q, reb_q, rrl_q, rrs_q, rst_st_q};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (cand_ok) begin
      cand_d = cand_w;
      if ({1'b0, cand_w} + {2'b0, run_q} <= {2'b0, total_q} &&
          (!bfound_q || cand_w < best_q)) begin
        ia_d = '0; pv_d = 1'b0; ov_d = 1'b0;
        state_d = StOscan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ia_q <= '0; jc_q <= '0; pv_q <= 1'b0; pidx_q <= '0;
      mode_q <= '0; key_q <= '0; len_q <= '0; found_q <= 1'b0; ffree_q <= 1'b0;
      slot_q <= '0; free_q <= '0; hit_q <= '0; run_q <= '0; cfirst_q <= 1'b0;
      bfound_q <= 1'b0; ov_q <= 1'b0; cand_q <= '0; best_q <= '0;
      valid_q <= '0; pin_q <= '0; live_q <= '0; seq_q <= '0; dirty_q <= 1'b0;
      lstart_q <= 16'd1; total_q <= 16'd4096; budget_q <= 16'd4095;
      rst_st_q <= StOk; rrs_q <= '0; rrl_q <= '0; reb_q <= '0; rseq_q <= '0;
      ract_q <= ActNone; ovld_q <= 1'b0; odata_q <= '0;
    end else begin
      state_q <= state_d; ia_q <= ia_d; jc_q <= jc_d; pv_q <= pv_d; pidx_q <= pidx_d;
      mode_q <= mode_d; key_q <= key_d; len_q <= len_d; found_q <= found_d;
      ffree_q <= ffree_d; slot_q <= slot_d; free_q <= free_d; hit_q <= hit_d;
      run_q <= run_d; cfirst_q <= cfirst_d; bfound_q <= bfound_d; ov_q <= ov_d;
      cand_q <= cand_d; best_q <= best_d; valid_q <= valid_d; pin_q <= pin_d;
      live_q <= live_d; seq_q <= seq_d; dirty_q <= dirty_d; lstart_q <= lstart_d;
      total_q <= total_d; budget_q <= budget_d; rst_st_q <= rst_st_d;
      rrs_q <= rrs_d; rrl_q <= rrl_d; reb_q <= reb_d; rseq_q <= rseq_d;
      ract_q <= ract_d; ovld_q <= ovld_d; odata_q <= odata_d;
    end
  end

  a_scan_valid_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOscan) |=> $stable(valid_q))
    else $error("valid marks changed during overlap scan");

  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> (!valid_q[free_q] && bfound_q))
    else $error("put writes into an occupied slot");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == StOut))
    else $error("result raised outside output state");

endmodule
